// ----- rtl/lcds_pkg.sv -----
// lcds_pkg: shared widths, reset values, config struct and result beat type
// for the logo dissolve sequencer. No dependencies.
package lcds_pkg;

    // item field widths
    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 9;
    localparam int CODE_W  = 8;

    // result field widths
    localparam int KIND_W = 2;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 6;

    // register widths
    localparam int LFSR_W = 16;
    localparam int CPT_W  = 6;
    localparam int HOLD_W = 8;

    // APB port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // logo geometry defaults
    localparam int DEF_LOGO_ROWS = 12;
    localparam int DEF_LOGO_COLS = 40;

    // hard ceiling on positions visited in one tick
    localparam logic [CPT_W-1:0] MAX_CELLS_PER_TICK = 6'd40;

    // register reset values
    localparam logic [LFSR_W-1:0] RST_SEED    = 16'h0001;
    localparam logic [CPT_W-1:0]  RST_CPT     = 6'd40;
    localparam logic [HOLD_W-1:0] RST_HOLD    = 8'd60;
    localparam logic [CODE_W-1:0] RST_GLYPH_A = 8'h21;
    localparam logic [CODE_W-1:0] RST_GLYPH_B = 8'h30;
    localparam logic [CODE_W-1:0] RST_GLYPH_C = 8'h35;

    typedef struct packed {
        logic [LFSR_W-1:0] lfsr_seed;
        logic [CPT_W-1:0]  cells_per_tick;
        logic [HOLD_W-1:0] hold_ticks;
        logic [CODE_W-1:0] glyph_code_a;
        logic [CODE_W-1:0] glyph_code_b;
        logic [CODE_W-1:0] glyph_code_c;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_col;
        logic [CODE_W-1:0] glyph;
        logic              draw_on;
        logic              last;
    } t_result;

endpackage

// ----- rtl/lcds_if.sv -----
// lcds_if: valid/ready channel interfaces for item beats and result beats.
// Depends on lcds_pkg for field widths.
interface lcds_in_if;
    logic                        valid;
    logic                        ready;
    logic [lcds_pkg::FUNC_W-1:0]  func;
    logic [lcds_pkg::INDEX_W-1:0] cell_index;
    logic [lcds_pkg::CODE_W-1:0]  cell_code;

    modport source (output valid, func, cell_index, cell_code, input ready);
    modport sink (input valid, func, cell_index, cell_code, output ready);
endinterface

interface lcds_out_if;
    logic                       valid;
    logic                       ready;
    logic [lcds_pkg::KIND_W-1:0] kind;
    logic [lcds_pkg::ROW_W-1:0]  cell_row;
    logic [lcds_pkg::COL_W-1:0]  cell_col;
    logic [lcds_pkg::CODE_W-1:0] glyph;
    logic                       draw_on;
    logic                       last;

    modport source (output valid, kind, cell_row, cell_col, glyph, draw_on, last,
                    input ready);
    modport sink (input valid, kind, cell_row, cell_col, glyph, draw_on, last,
                  output ready);
endinterface

// ----- rtl/lfsr_cell_dissolve_sequencer_core.sv -----
// lfsr_cell_dissolve_sequencer_core: top level of the logo dissolve sequencer.
// Depends on lcds_pkg, lcds_if, lcds_cfg and lcds_seq.
//
//  channel   dir   handshake                    carries
//  i_in      in    valid/ready                  func, cell_index, cell_code
//  o_out     out   valid/ready                  kind, cell_row, cell_col, glyph, draw_on, last
//  apb       in    psel/penable/pwrite/pready   six config registers at 4*i
//
// load, restart and ignored items, and a quiet hold tick, are handled in S_IDLE alone; a tick
// that ends the hold or comes after the fade-out passes through S_FLUSH as well.
// a fade tick walks, per visited position, S_FADE, then S_STEP for each LFSR step up to
// and including the one that lands in the logo (the store is read on that step), then
// S_CHECK, plus S_DIV and S_PUSH on a matching cell. the single-step LFSR loop sets the
// length of a full tick.
// reset is synchronous, active low; the logo store needs no clearing pass.
// a stalled result beat holds the sequencer only when it must pass a second beat.
module lfsr_cell_dissolve_sequencer_core #(
    parameter int LOGO_ROWS = lcds_pkg::DEF_LOGO_ROWS,
    parameter int LOGO_COLS = lcds_pkg::DEF_LOGO_COLS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lcds_in_if.sink                         i_in,
    lcds_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lcds_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lcds_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lcds_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    lcds_pkg::t_cfg cfg;

    lcds_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lcds_seq #(
        .LOGO_ROWS (LOGO_ROWS),
        .LOGO_COLS (LOGO_COLS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/lcds_ram.sv -----
// lcds_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lcds_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 480,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lcds_cfg.sv -----
// lcds_cfg: APB register file holding seed, pacing and glyph code settings.
// Depends on lcds_pkg for the config struct and reset values.
module lcds_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lcds_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lcds_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lcds_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output lcds_pkg::t_cfg                  o_cfg
);

    localparam logic [2:0] REG_SEED    = 3'd0;
    localparam logic [2:0] REG_CPT     = 3'd1;
    localparam logic [2:0] REG_HOLD    = 3'd2;
    localparam logic [2:0] REG_GLYPH_A = 3'd3;
    localparam logic [2:0] REG_GLYPH_B = 3'd4;
    localparam logic [2:0] REG_GLYPH_C = 3'd5;

    lcds_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lfsr_seed      <= lcds_pkg::RST_SEED;
            r_cfg.cells_per_tick <= lcds_pkg::RST_CPT;
            r_cfg.hold_ticks     <= lcds_pkg::RST_HOLD;
            r_cfg.glyph_code_a   <= lcds_pkg::RST_GLYPH_A;
            r_cfg.glyph_code_b   <= lcds_pkg::RST_GLYPH_B;
            r_cfg.glyph_code_c   <= lcds_pkg::RST_GLYPH_C;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SEED:    r_cfg.lfsr_seed      <= pwdata[lcds_pkg::LFSR_W-1:0];
                REG_CPT:     r_cfg.cells_per_tick <= pwdata[lcds_pkg::CPT_W-1:0];
                REG_HOLD:    r_cfg.hold_ticks     <= pwdata[lcds_pkg::HOLD_W-1:0];
                REG_GLYPH_A: r_cfg.glyph_code_a   <= pwdata[lcds_pkg::CODE_W-1:0];
                REG_GLYPH_B: r_cfg.glyph_code_b   <= pwdata[lcds_pkg::CODE_W-1:0];
                REG_GLYPH_C: r_cfg.glyph_code_c   <= pwdata[lcds_pkg::CODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SEED:    prdata = lcds_pkg::APB_DATA_W'(r_cfg.lfsr_seed);
            REG_CPT:     prdata = lcds_pkg::APB_DATA_W'(r_cfg.cells_per_tick);
            REG_HOLD:    prdata = lcds_pkg::APB_DATA_W'(r_cfg.hold_ticks);
            REG_GLYPH_A: prdata = lcds_pkg::APB_DATA_W'(r_cfg.glyph_code_a);
            REG_GLYPH_B: prdata = lcds_pkg::APB_DATA_W'(r_cfg.glyph_code_b);
            REG_GLYPH_C: prdata = lcds_pkg::APB_DATA_W'(r_cfg.glyph_code_c);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/lcds_seq.sv -----
// lcds_seq: logo store, LFSR walker, row/column divider and result staging.
// Depends on lcds_pkg, lcds_if and lcds_ram.
module lcds_seq #(
    parameter int LOGO_ROWS = lcds_pkg::DEF_LOGO_ROWS,
    parameter int LOGO_COLS = lcds_pkg::DEF_LOGO_COLS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lcds_pkg::t_cfg i_cfg,
    lcds_in_if.sink        i_in,
    lcds_out_if.source     o_out
);

    localparam int CELLS   = LOGO_ROWS * LOGO_COLS;
    localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int VIS_W   = $clog2(CELLS + 1);
    localparam int QROW_W  = (LOGO_ROWS > 1) ? $clog2(LOGO_ROWS) : 1;
    localparam int RCP_SH  = ADDR_W + $clog2(LOGO_COLS) + 1;
    localparam int RCP_W   = RCP_SH + 1;
    localparam int PROD_W  = ADDR_W + RCP_W;
    localparam int LW      = lcds_pkg::LFSR_W;

    localparam logic [LW-1:0]     CELLS_L   = LW'(CELLS);
    localparam logic [VIS_W-1:0]  CELLS_V   = VIS_W'(CELLS);
    // rounded-up reciprocal of the column count, exact for every cell address
    localparam logic [RCP_W-1:0]  COL_RCP   = RCP_W'(((1 << RCP_SH) + LOGO_COLS - 1) / LOGO_COLS);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(LOGO_COLS);
    localparam logic [LW-1:0]     LFSR_TAPS = 16'hB400;

    localparam logic [1:0] FN_LOAD    = 2'd0;
    localparam logic [1:0] FN_TICK    = 2'd1;
    localparam logic [1:0] FN_RESTART = 2'd2;

    localparam logic [1:0] PH_FADE_IN  = 2'd0;
    localparam logic [1:0] PH_HOLD     = 2'd1;
    localparam logic [1:0] PH_FADE_OUT = 2'd2;
    localparam logic [1:0] PH_DONE     = 2'd3;

    localparam logic [1:0] KIND_CELL   = 2'd0;
    localparam logic [1:0] KIND_TEXT   = 2'd1;
    localparam logic [1:0] KIND_ERASE  = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FADE  = 3'd1;
    localparam logic [2:0] S_STEP  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;
    localparam logic [2:0] S_ENDF  = 3'd6;
    localparam logic [2:0] S_FLUSH = 3'd7;

    function automatic logic [LW-1:0] lfsr_step(input logic [LW-1:0] w);
        logic [LW-1:0] s;
        s = w >> 1;
        if (w[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

    function automatic lcds_pkg::t_result make_event(input logic [1:0] k);
        lcds_pkg::t_result r;
        r      = '0;
        r.kind = k;
        return r;
    endfunction

    logic [2:0]                    r_fsm, n_fsm;
    logic [1:0]                    r_phase, n_phase;
    logic [LW-1:0]                 r_lfsr, n_lfsr;
    logic [VIS_W-1:0]              r_visited, n_visited;
    logic [lcds_pkg::HOLD_W-1:0]   r_hold, n_hold;
    logic [lcds_pkg::CPT_W-1:0]    r_iter, n_iter;
    logic [ADDR_W-1:0]             r_pos, n_pos;
    logic [lcds_pkg::CODE_W-1:0]   r_code, n_code;
    logic [QROW_W-1:0]             r_row, n_row;
    lcds_pkg::t_result             r_pend, n_pend;
    logic                          r_pend_valid, n_pend_valid;
    lcds_pkg::t_result             r_out, n_out;
    logic                          r_out_valid, n_out_valid;

    logic                          accept;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [lcds_pkg::CODE_W-1:0]   ram_rdata;
    logic [LW-1:0]                 lfsr_nx;
    logic                          hit;
    logic                          glyph_hit;
    logic                          out_free;
    logic                          can_push;
    logic                          push_req;
    lcds_pkg::t_result             push_res;
    logic [lcds_pkg::CPT_W-1:0]    limit;
    logic                          more;
    logic [PROD_W-1:0]             row_prod;
    logic [ADDR_W-1:0]             col_calc;
    logic [lcds_pkg::HOLD_W-1:0]   hold_nx;

    assign i_in.ready = (r_fsm == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    assign ram_we    = accept && (i_in.func == FN_LOAD)
                       && (LW'(i_in.cell_index) < CELLS_L);
    assign ram_waddr = ADDR_W'(i_in.cell_index);

    assign lfsr_nx   = lfsr_step(r_lfsr);
    assign hit       = (lfsr_nx != '0) && (lfsr_nx <= CELLS_L);
    // read runs every cycle; data is used only the cycle after a hit
    assign ram_raddr = ADDR_W'(lfsr_nx - 16'd1);

    lcds_ram #(
        .WIDTH (lcds_pkg::CODE_W),
        .DEPTH (CELLS)
    ) u_logo_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in.cell_code),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign glyph_hit = (ram_rdata == i_cfg.glyph_code_a) || (ram_rdata == i_cfg.glyph_code_b)
                       || (ram_rdata == i_cfg.glyph_code_c);

    assign limit = (i_cfg.cells_per_tick > lcds_pkg::MAX_CELLS_PER_TICK)
                   ? lcds_pkg::MAX_CELLS_PER_TICK : i_cfg.cells_per_tick;
    assign more  = (r_iter < limit) && (r_visited < CELLS_V);

    assign out_free = !r_out_valid || o_out.ready;
    // pending beat must move out before a new one can take its place
    assign can_push = !r_pend_valid || out_free;
    assign row_prod = PROD_W'(r_pos) * PROD_W'(COL_RCP);
    assign col_calc = r_pos - ADDR_W'(r_row) * COLS_A;
    assign hold_nx  = r_hold + 8'd1;

    always_comb begin
        n_fsm        = r_fsm;
        n_phase      = r_phase;
        n_lfsr       = r_lfsr;
        n_visited    = r_visited;
        n_hold       = r_hold;
        n_iter       = r_iter;
        n_pos        = r_pos;
        n_code       = r_code;
        n_row        = r_row;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        push_req     = 1'b0;
        push_res     = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_fsm)
            S_IDLE: begin
                if (accept) begin
                    case (i_in.func)
                        FN_RESTART: begin
                            n_lfsr    = (i_cfg.lfsr_seed != '0) ? i_cfg.lfsr_seed : 16'd1;
                            n_phase   = PH_FADE_IN;
                            n_visited = '0;
                            n_hold    = '0;
                        end
                        FN_TICK: begin
                            case (r_phase)
                                PH_FADE_IN, PH_FADE_OUT: begin
                                    n_iter = '0;
                                    n_fsm  = S_FADE;
                                end
                                PH_HOLD: begin
                                    n_hold = hold_nx;
                                    if (hold_nx >= i_cfg.hold_ticks) begin
                                        n_pend       = make_event(KIND_ERASE);
                                        n_pend_valid = 1'b1;
                                        n_phase      = PH_FADE_OUT;
                                        n_visited    = '0;
                                        n_fsm        = S_FLUSH;
                                    end
                                end
                                default: begin
                                    n_pend       = make_event(KIND_FINISH);
                                    n_pend_valid = 1'b1;
                                    n_fsm        = S_FLUSH;
                                end
                            endcase
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FADE: begin
                n_fsm = more ? S_STEP : S_ENDF;
            end
            S_STEP: begin
                n_lfsr = lfsr_nx;
                if (hit) begin
                    n_pos     = ram_raddr;
                    n_visited = r_visited + 1'b1;
                    n_iter    = r_iter + 1'b1;
                    n_fsm     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (glyph_hit) begin
                    n_code = ram_rdata;
                    n_fsm  = S_DIV;
                end else begin
                    n_fsm = S_FADE;
                end
            end
            S_DIV: begin
                // row by reciprocal multiplication, column follows in the push cycle
                n_row = row_prod[RCP_SH +: QROW_W];
                n_fsm = S_PUSH;
            end
            S_PUSH: begin
                push_req          = 1'b1;
                push_res.kind     = KIND_CELL;
                push_res.cell_row = lcds_pkg::ROW_W'(r_row);
                push_res.cell_col = lcds_pkg::COL_W'(col_calc);
                push_res.glyph    = r_code;
                push_res.draw_on  = (r_phase == PH_FADE_IN);
                if (can_push) begin
                    n_fsm = S_FADE;
                end
            end
            S_ENDF: begin
                if (r_visited >= CELLS_V) begin
                    push_req = 1'b1;
                    push_res = make_event((r_phase == PH_FADE_IN) ? KIND_TEXT : KIND_FINISH);
                    if (can_push) begin
                        if (r_phase == PH_FADE_IN) begin
                            n_phase = PH_HOLD;
                            n_hold  = '0;
                        end else begin
                            n_phase = PH_DONE;
                        end
                        n_fsm = S_FLUSH;
                    end
                end else begin
                    n_fsm = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_fsm = S_IDLE;
                end else if (out_free) begin
                    n_out        = r_pend;
                    n_out.last   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_fsm        = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase

        if (push_req && can_push) begin
            if (r_pend_valid) begin
                n_out       = r_pend;
                n_out.last  = 1'b0;
                n_out_valid = 1'b1;
            end
            n_pend       = push_res;
            n_pend_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm        <= S_IDLE;
            r_phase      <= PH_FADE_IN;
            r_lfsr       <= 16'd1;
            r_visited    <= '0;
            r_hold       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_fsm        <= n_fsm;
            r_phase      <= n_phase;
            r_lfsr       <= n_lfsr;
            r_visited    <= n_visited;
            r_hold       <= n_hold;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iter <= n_iter;
        r_pos  <= n_pos;
        r_code <= n_code;
        r_row  <= n_row;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.kind     = r_out.kind;
    assign o_out.cell_row = r_out.cell_row;
    assign o_out.cell_col = r_out.cell_col;
    assign o_out.glyph    = r_out.glyph;
    assign o_out.draw_on  = r_out.draw_on;
    assign o_out.last     = r_out.last;

endmodule
